FILE: rtl/palette_error_diffusion_dither_macros.svh
// assertion macros for the dither rtl
`ifndef PALETTE_ERROR_DIFFUSION_DITHER_MACROS_SVH
`define PALETTE_ERROR_DIFFUSION_DITHER_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define PED_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dither assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define PED_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dither assertion failed");

`endif

FILE: rtl/ped_pkg.sv
// types and constants for the palette dither
`timescale 1ns / 1ps
`default_nettype none

package ped_pkg;

    localparam int MAX_WIDTH_DEF    = 1024;
    localparam int PALETTE_SIZE_DEF = 8;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    localparam logic [CFG_IDX_W-1:0] REG_PAIR0  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAIR1  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PAIR2  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PAIR3  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd6;

    localparam int IDX_W   = 3;
    localparam int VAL_W   = 13;
    localparam int ERR_W   = 13;
    localparam int WDIFF_W = 24;
    localparam int SQ_W    = 46;
    localparam int DIST_W  = 48;

    // luma weights in thousandths
    localparam logic [9:0] WT_RED   = 10'd299;
    localparam logic [9:0] WT_GREEN = 10'd587;
    localparam logic [9:0] WT_BLUE  = 10'd114;

    typedef logic signed [ERR_W-1:0] err_t;

    typedef struct packed {
        err_t r;
        err_t g;
        err_t b;
    } errv_t;

    typedef struct packed {
        logic [VAL_W-1:0] r;
        logic [VAL_W-1:0] g;
        logic [VAL_W-1:0] b;
    } val_t;

    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] idx;
    } dtag_t;

endpackage

`default_nettype wire

FILE: rtl/ped_dist.sv
// pipelined weighted squared distance from a pixel to one palette colour
`timescale 1ns / 1ps
`default_nettype none

module ped_dist
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire ped_pkg::val_t             val,
    input  wire logic [23:0]               colour,
    input  wire ped_pkg::dtag_t            tag_in,
    output      logic [ped_pkg::DIST_W-1:0] distance,
    output      ped_pkg::dtag_t            tag_out,
    output      logic                      busy
);

    logic signed [ped_pkg::WDIFF_W-1:0] wd_r_reg, wd_g_reg, wd_b_reg;
    logic [ped_pkg::SQ_W-1:0]           sq_r_reg, sq_g_reg, sq_b_reg;
    ped_pkg::dtag_t                     tag1_reg, tag2_reg;

    function automatic logic signed [ped_pkg::WDIFF_W-1:0] wdiff(
        logic [ped_pkg::VAL_W-1:0] v,
        logic [7:0]                c,
        logic [9:0]                wt
    );
        logic signed [13:0] d;
        d = signed'({1'b0, v}) - signed'({2'b00, c, 4'b0000});
        return d * signed'({1'b0, wt});
    endfunction

    function automatic logic [ped_pkg::SQ_W-1:0] square(
        logic signed [ped_pkg::WDIFF_W-1:0] a
    );
        logic [ped_pkg::WDIFF_W-2:0] m;
        m = (a < 0) ? (ped_pkg::WDIFF_W-1)'(-a) : (ped_pkg::WDIFF_W-1)'(a);
        return m * m;
    endfunction

    always_ff @(posedge clk)
    begin
        wd_r_reg <= wdiff(val.r, colour[23:16], ped_pkg::WT_RED);
        wd_g_reg <= wdiff(val.g, colour[15:8], ped_pkg::WT_GREEN);
        wd_b_reg <= wdiff(val.b, colour[7:0], ped_pkg::WT_BLUE);
        sq_r_reg <= square(wd_r_reg);
        sq_g_reg <= square(wd_g_reg);
        sq_b_reg <= square(wd_b_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg <= '0;
            tag2_reg <= '0;
        end
        else
        begin
            tag1_reg <= tag_in;
            tag2_reg <= tag1_reg;
        end
    end

    assign distance = ped_pkg::DIST_W'(sq_r_reg) + ped_pkg::DIST_W'(sq_g_reg)
                    + ped_pkg::DIST_W'(sq_b_reg);
    assign tag_out = tag2_reg;
    assign busy    = tag1_reg.valid | tag2_reg.valid;

endmodule

`default_nettype wire

FILE: rtl/palette_error_diffusion_dither.sv
// top level: floyd-steinberg error diffusion onto a programmable palette
//
// pixels enter on s_axis (tdata = red, green, blue from the low byte up) in
// raster order; each one yields one transaction on m_axis carrying the chosen
// palette colour and index, with tlast on the last pixel of the image.
// the error line read issued at acceptance returns in the cycle that forms
// the corrected pixel; the single distance unit then takes one palette entry
// per cycle, count being the palette entries in use, and is drained; a final
// step picks the colour and writes back the error. the last pixel of a row
// other than the last row takes an extra step for a second memory write (one
// write port).
// the next pixel is accepted once the previous one is written back.
// after reset and after the last pixel of every image the error line memory
// is swept to zero, all MAX_WIDTH entries, with s_axis_tready low; config
// writes are taken as usual. the result waits in an output register while
// m_axis stalls, and a new pixel may still be accepted; the block holds in
// its write back cycle only if that register is still full.
// config: cfg_we with cfg_index and cfg_data writes one register per cycle.
`timescale 1ns / 1ps
`default_nettype none

`include "palette_error_diffusion_dither_macros.svh"

module palette_error_diffusion_dither
#(
    parameter int MAX_WIDTH    = ped_pkg::MAX_WIDTH_DEF,
    parameter int PALETTE_SIZE = ped_pkg::PALETTE_SIZE_DEF
)
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [ped_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [ped_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                            s_axis_tvalid,
    output      logic                            s_axis_tready,
    // in_red, in_green, in_blue
    input  wire logic [23:0]                     s_axis_tdata,
    output      logic                            m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // out_red, out_green, out_blue, colour_index, zero fill
    output      logic [31:0]                     m_axis_tdata,
    output      logic                            m_axis_tlast
);

    localparam int XW  = $clog2(MAX_WIDTH);
    localparam int CW  = (XW + 1 > 11) ? XW + 1 : 11;
    localparam int CAP = (PALETTE_SIZE < 8) ? PALETTE_SIZE : 8;

    localparam logic [2:0] ST_CLR   = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_VAL   = 3'd2;
    localparam logic [2:0] ST_SRCH  = 3'd3;
    localparam logic [2:0] ST_DRAIN = 3'd4;
    localparam logic [2:0] ST_ERR   = 3'd5;
    localparam logic [2:0] ST_WR2   = 3'd6;

    logic [2:0]  state_reg, state_next;

    logic [47:0] pair0_reg, pair1_reg, pair2_reg, pair3_reg;
    logic [3:0]  count_reg;
    logic [10:0] width_reg;
    logic [15:0] height_reg;

    logic [XW-1:0] x_reg, x_next;
    logic [15:0]   y_reg, y_next;
    logic [XW-1:0] clr_addr_reg, clr_addr_next;

    ped_pkg::errv_t rc_reg, rc_next;
    ped_pkg::errv_t bp0_reg, bp0_next;
    ped_pkg::errv_t bp1_reg, bp1_next;
    ped_pkg::errv_t wr2_data_reg, wr2_data_next;
    logic [XW-1:0]  wr2_addr_reg, wr2_addr_next;

    logic [23:0]    pix_reg;
    ped_pkg::val_t  val_reg, val_next;
    logic [ped_pkg::IDX_W-1:0] issue_idx_reg, issue_idx_next;
    logic [ped_pkg::IDX_W-1:0] best_idx_reg;
    logic [ped_pkg::DIST_W-1:0] best_dist_reg;

    logic [ped_pkg::ERR_W*3-1:0] line_mem [MAX_WIDTH];
    ped_pkg::errv_t rd_reg;
    logic           mem_re, mem_we;
    logic [XW-1:0]  mem_waddr;
    ped_pkg::errv_t mem_wdata;

    logic           out_valid_reg;
    logic [26:0]    out_data_reg;
    logic           out_last_reg;

    logic [191:0]   palette;
    logic [3:0]     cnt_eff;
    logic [CW-1:0]  w_ext, w_eff;
    logic [15:0]    h_eff;
    logic           last_col, last_row;
    logic           accept, adv;

    logic [23:0]    col_issue, col_best;
    ped_pkg::dtag_t tag_issue, tag_out;
    logic [ped_pkg::DIST_W-1:0] distance;
    logic           dist_busy;

    ped_pkg::errv_t e_v, s7_v, s5_v, s3_v, s1_v, nbp0;

    function automatic logic [ped_pkg::VAL_W-1:0] clamp_val(
        logic [7:0]    pix,
        ped_pkg::err_t a,
        ped_pkg::err_t b
    );
        logic signed [14:0] s;
        s = signed'({3'b000, pix, 4'b0000}) + 15'(a) + 15'(b);
        if (s < 0)
            return '0;
        else if (s > 15'sd4080)
            return 13'd4080;
        else
            return ped_pkg::VAL_W'(s);
    endfunction

    // floor(e * k / 16)
    function automatic ped_pkg::err_t share(ped_pkg::err_t e, logic [2:0] k);
        logic signed [16:0] p;
        p = e * signed'({1'b0, k});
        return ped_pkg::ERR_W'(p >>> 4);
    endfunction

    function automatic ped_pkg::errv_t share_v(ped_pkg::errv_t e, logic [2:0] k);
        ped_pkg::errv_t r;
        r.r = share(e.r, k);
        r.g = share(e.g, k);
        r.b = share(e.b, k);
        return r;
    endfunction

    function automatic ped_pkg::errv_t add_v(ped_pkg::errv_t a, ped_pkg::errv_t b);
        ped_pkg::errv_t r;
        r.r = a.r + b.r;
        r.g = a.g + b.g;
        r.b = a.b + b.b;
        return r;
    endfunction

    function automatic ped_pkg::err_t err_of(logic [ped_pkg::VAL_W-1:0] v, logic [7:0] c);
        logic signed [13:0] d;
        d = signed'({1'b0, v}) - signed'({2'b00, c, 4'b0000});
        return ped_pkg::ERR_W'(d);
    endfunction

    // effective geometry and palette size
    assign palette = {pair3_reg, pair2_reg, pair1_reg, pair0_reg};
    assign cnt_eff = (count_reg == 4'd0) ? 4'd1 :
                     ((count_reg > 4'(CAP)) ? 4'(CAP) : count_reg);
    assign w_ext   = CW'(width_reg);
    assign w_eff   = (width_reg == 11'd0) ? CW'(1) :
                     ((w_ext > CW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : w_ext);
    assign h_eff   = (height_reg == 16'd0) ? 16'd1 : height_reg;
    assign last_col = (CW'(x_reg) + CW'(1)) >= w_eff;
    assign last_row = ({1'b0, y_reg} + 17'd1) >= {1'b0, h_eff};

    assign col_issue = palette[issue_idx_reg * 24 +: 24];
    assign col_best  = palette[best_idx_reg * 24 +: 24];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept = s_axis_tvalid & s_axis_tready;
    assign adv    = !out_valid_reg || m_axis_tready;

    assign tag_issue.valid = (state_reg == ST_SRCH);
    assign tag_issue.idx   = issue_idx_reg;

    ped_dist u_dist
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .val     (val_reg),
        .colour  (col_issue),
        .tag_in  (tag_issue),
        .distance(distance),
        .tag_out (tag_out),
        .busy    (dist_busy)
    );

    // quantisation error and its shares
    always_comb
    begin
        e_v.r = err_of(val_reg.r, col_best[23:16]);
        e_v.g = err_of(val_reg.g, col_best[15:8]);
        e_v.b = err_of(val_reg.b, col_best[7:0]);
        s7_v  = share_v(e_v, 3'd7);
        s5_v  = share_v(e_v, 3'd5);
        s3_v  = share_v(e_v, 3'd3);
        s1_v  = share_v(e_v, 3'd1);
        nbp0  = add_v(bp1_reg, s5_v);
    end

    // error line memory port
    always_comb
    begin
        mem_re    = accept;
        mem_we    = 1'b0;
        mem_waddr = x_reg - XW'(1);
        mem_wdata = add_v(bp0_reg, s3_v);
        case (state_reg)
            ST_CLR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_addr_reg;
                mem_wdata = '0;
            end
            ST_ERR:
            begin
                mem_we = adv && !last_row && (x_reg != '0);
            end
            ST_WR2:
            begin
                mem_we    = 1'b1;
                mem_waddr = wr2_addr_reg;
                mem_wdata = wr2_data_reg;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            line_mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_reg <= line_mem[x_reg];
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        clr_addr_next  = clr_addr_reg;
        rc_next        = rc_reg;
        bp0_next       = bp0_reg;
        bp1_next       = bp1_reg;
        wr2_data_next  = wr2_data_reg;
        wr2_addr_next  = wr2_addr_reg;
        val_next       = val_reg;
        issue_idx_next = issue_idx_reg;
        case (state_reg)
            ST_CLR:
            begin
                if (clr_addr_reg == XW'(MAX_WIDTH - 1))
                begin
                    clr_addr_next = '0;
                    state_next    = ST_IDLE;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + XW'(1);
                end
            end
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_VAL;
            end
            ST_VAL:
            begin
                val_next.r     = clamp_val(pix_reg[7:0], rd_reg.r, rc_reg.r);
                val_next.g     = clamp_val(pix_reg[15:8], rd_reg.g, rc_reg.g);
                val_next.b     = clamp_val(pix_reg[23:16], rd_reg.b, rc_reg.b);
                issue_idx_next = '0;
                state_next     = ST_SRCH;
            end
            ST_SRCH:
            begin
                if ({1'b0, issue_idx_reg} == cnt_eff - 4'd1)
                    state_next = ST_DRAIN;
                else
                    issue_idx_next = issue_idx_reg + ped_pkg::IDX_W'(1);
            end
            ST_DRAIN:
            begin
                if (!dist_busy)
                    state_next = ST_ERR;
            end
            ST_ERR:
            begin
                if (adv)
                begin
                    rc_next = s7_v;
                    if (!last_row)
                    begin
                        bp0_next = nbp0;
                        bp1_next = s1_v;
                    end
                    if (last_col)
                    begin
                        rc_next       = '0;
                        bp0_next      = '0;
                        bp1_next      = '0;
                        x_next        = '0;
                        wr2_data_next = nbp0;
                        wr2_addr_next = x_reg;
                        if (last_row)
                        begin
                            y_next     = '0;
                            state_next = ST_CLR;
                        end
                        else
                        begin
                            y_next     = y_reg + 16'd1;
                            state_next = ST_WR2;
                        end
                    end
                    else
                    begin
                        x_next     = x_reg + XW'(1);
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_WR2:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLR;
            x_reg         <= '0;
            y_reg         <= '0;
            clr_addr_reg  <= '0;
            rc_reg        <= '0;
            bp0_reg       <= '0;
            bp1_reg       <= '0;
            issue_idx_reg <= '0;
            out_valid_reg <= 1'b0;
            pair0_reg     <= '0;
            pair1_reg     <= '0;
            pair2_reg     <= '0;
            pair3_reg     <= '0;
            count_reg     <= 4'd1;
            width_reg     <= 11'd1;
            height_reg    <= 16'd1;
        end
        else
        begin
            state_reg     <= state_next;
            x_reg         <= x_next;
            y_reg         <= y_next;
            clr_addr_reg  <= clr_addr_next;
            rc_reg        <= rc_next;
            bp0_reg       <= bp0_next;
            bp1_reg       <= bp1_next;
            issue_idx_reg <= issue_idx_next;
            if (state_reg == ST_ERR && adv)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
            if (cfg_we)
            begin
                case (cfg_index)
                    ped_pkg::REG_PAIR0:  pair0_reg  <= cfg_data;
                    ped_pkg::REG_PAIR1:  pair1_reg  <= cfg_data;
                    ped_pkg::REG_PAIR2:  pair2_reg  <= cfg_data;
                    ped_pkg::REG_PAIR3:  pair3_reg  <= cfg_data;
                    ped_pkg::REG_COUNT:  count_reg  <= cfg_data[3:0];
                    ped_pkg::REG_WIDTH:  width_reg  <= cfg_data[10:0];
                    ped_pkg::REG_HEIGHT: height_reg <= cfg_data[15:0];
                    default:             ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        val_reg      <= val_next;
        wr2_data_reg <= wr2_data_next;
        wr2_addr_reg <= wr2_addr_next;
        if (accept)
            pix_reg <= s_axis_tdata;
        // running minimum, ties keep the lower index
        if (tag_out.valid && (tag_out.idx == '0 || distance < best_dist_reg))
        begin
            best_dist_reg <= distance;
            best_idx_reg  <= tag_out.idx;
        end
        if (state_reg == ST_ERR && adv)
        begin
            out_data_reg <= {best_idx_reg, col_best[7:0], col_best[15:8], col_best[23:16]};
            out_last_reg <= last_col && last_row;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b00000, out_data_reg};
    assign m_axis_tlast  = out_last_reg;

    `PED_ASSERT_NXT(a_accept_starts_clean, accept, state_reg == ST_VAL && !dist_busy)
    `PED_ASSERT_NXT(a_image_end_clears,
        state_reg == ST_ERR && adv && last_col && last_row,
        state_reg == ST_CLR && x_reg == '0 && y_reg == '0 && m_axis_tlast)
    `PED_ASSERT_IMP(a_best_in_range, state_reg == ST_ERR, {1'b0, best_idx_reg} < cnt_eff)

endmodule

`default_nettype wire

FILE: test/tb_palette_error_diffusion_dither.sv
// self-checking testbench for the palette error-diffusion dither
`timescale 1ns / 1ps

module tb_palette_error_diffusion_dither;

    localparam int LINE_DEPTH = 1024;
    localparam int PAL_CAP    = 8;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [2:0] idx;
        logic       eoi;
    } pixel_out_t;

    typedef struct packed {
        logic                          is_cfg;
        logic [ped_pkg::CFG_IDX_W-1:0] reg_idx;
        logic [47:0]                   reg_val;
        logic [23:0]                   pix;
        logic                          typed;
        logic [23:0]                   rgb;
        logic [2:0]                    idx;
        logic                          eoi;
    } dir_row_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           cfg_we = 1'b0;
    logic [ped_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [ped_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [23:0]                    s_axis_tdata = '0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [31:0]                    m_axis_tdata;
    logic                           m_axis_tlast;

    palette_error_diffusion_dither u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // shadow of the block's registers and diffusion state
    logic [47:0] pal_pair [4];
    logic [3:0]  pal_count;
    logic [10:0] img_width;
    logic [15:0] img_height;
    int          line_err [LINE_DEPTH][3];
    int          carry_err [3];
    int          below_err [2][3];
    int          col_pos;
    int          row_pos;

    pixel_out_t  dithered_q [$];
    int          errors = 0;
    int          sent = 0;
    bit          no_idle = 1'b0;

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        #100ms;
        $display("tb: failure");
        $finish;
    end

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        errors++;
    endtask

    function automatic void clear_diffusion();
        for (int i = 0; i < LINE_DEPTH; i++)
            for (int c = 0; c < 3; c++)
                line_err[i][c] = 0;
        for (int c = 0; c < 3; c++)
        begin
            carry_err[c] = 0;
            below_err[0][c] = 0;
            below_err[1][c] = 0;
        end
        col_pos = 0;
        row_pos = 0;
    endfunction

    function automatic logic [23:0] pal_colour(input int i);
        logic [47:0] pair;
        pair = pal_pair[i >> 1];
        return (i & 1) ? pair[47:24] : pair[23:0];
    endfunction

    // channel 0 red (bits 23:16), 1 green, 2 blue
    function automatic int chan(input logic [23:0] colour, input int c);
        return int'((colour >> (16 - 8 * c)) & 24'hFF);
    endfunction

    function automatic pixel_out_t dither_pixel(input logic [23:0] pix);
        pixel_out_t  res;
        int          cnt;
        int          w;
        int          h;
        int          x;
        int          y;
        bit          last_col;
        bit          last_row;
        int          val [3];
        int          e [3];
        int          s;
        int          best;
        longint      best_d;
        longint      d;
        longint      diff;
        longint      wt [3];
        logic [23:0] colour;
        logic [7:0]  in_ch [3];
        wt = '{299, 587, 114};
        in_ch[0] = pix[7:0];
        in_ch[1] = pix[15:8];
        in_ch[2] = pix[23:16];
        cnt = (pal_count == 0) ? 1 : pal_count;
        if (cnt > PAL_CAP)
            cnt = PAL_CAP;
        w = (img_width == 0) ? 1 : img_width;
        if (w > LINE_DEPTH)
            w = LINE_DEPTH;
        h = (img_height == 0) ? 1 : img_height;
        x = col_pos;
        y = row_pos;
        last_col = (x + 1 >= w);
        last_row = (y + 1 >= h);
        for (int c = 0; c < 3; c++)
        begin
            val[c] = int'(in_ch[c]) * 16 + line_err[x % LINE_DEPTH][c] + carry_err[c];
            if (val[c] < 0)
                val[c] = 0;
            if (val[c] > 4080)
                val[c] = 4080;
        end
        best = 0;
        best_d = 0;
        for (int i = 0; i < cnt; i++)
        begin
            d = 0;
            for (int c = 0; c < 3; c++)
            begin
                diff = (longint'(val[c]) - longint'(chan(pal_colour(i), c)) * 16) * wt[c];
                d += diff * diff;
            end
            if (i == 0 || d < best_d)
            begin
                best_d = d;
                best = i;
            end
        end
        colour = pal_colour(best);
        for (int c = 0; c < 3; c++)
            e[c] = val[c] - chan(colour, c) * 16;
        // shares round toward minus infinity
        for (int c = 0; c < 3; c++)
        begin
            carry_err[c] = last_col ? 0 : ((e[c] * 7) >>> 4);
            if (!last_row)
            begin
                s = (e[c] * 3) >>> 4;
                if (x > 0)
                    line_err[(x - 1) % LINE_DEPTH][c] = below_err[0][c] + s;
                below_err[0][c] = below_err[1][c] + ((e[c] * 5) >>> 4);
                below_err[1][c] = last_col ? 0 : (e[c] >>> 4);
                if (last_col)
                    line_err[x % LINE_DEPTH][c] = below_err[0][c];
            end
        end
        res.red = colour[23:16];
        res.green = colour[15:8];
        res.blue = colour[7:0];
        res.idx = best[2:0];
        res.eoi = last_col && last_row;
        if (last_col)
        begin
            for (int c = 0; c < 3; c++)
            begin
                carry_err[c] = 0;
                below_err[0][c] = 0;
                below_err[1][c] = 0;
            end
            col_pos = 0;
            if (last_row)
                clear_diffusion();
            else
                row_pos = y + 1;
        end
        else
        begin
            col_pos = x + 1;
        end
        return res;
    endfunction

    // raises cfg_we; the caller lowers it once after a burst of writes
    task automatic write_reg(input logic [ped_pkg::CFG_IDX_W-1:0] ri, input logic [47:0] v);
        cfg_we <= 1'b1;
        cfg_index <= ri;
        cfg_data <= v;
        @(posedge clk);
        case (ri)
            ped_pkg::REG_PAIR0:  pal_pair[0] = v;
            ped_pkg::REG_PAIR1:  pal_pair[1] = v;
            ped_pkg::REG_PAIR2:  pal_pair[2] = v;
            ped_pkg::REG_PAIR3:  pal_pair[3] = v;
            ped_pkg::REG_COUNT:  pal_count = v[3:0];
            ped_pkg::REG_WIDTH:  img_width = v[10:0];
            ped_pkg::REG_HEIGHT: img_height = v[15:0];
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (dithered_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic send_pixel(input logic [23:0] pix, input bit typed, input pixel_out_t want);
        pixel_out_t res;
        int         gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= pix;
        do
            @(posedge clk);
        while (!s_axis_tready);
        res = dither_pixel(pix);
        dithered_q.push_back(typed ? want : res);
        sent++;
        gap = no_idle ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic logic [47:0] rand_pair();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            default: return 48'({$urandom, $urandom});
        endcase
    endfunction

    function automatic logic [7:0] rand_chan();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // result side: random back-pressure per transaction
    initial
    begin
        int k;
        @(posedge rst_n);
        forever
        begin
            k = no_idle ? 0 : $urandom_range(0, 12);
            if (k > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (k) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
        end
    end

    always @(posedge clk)
    begin
        pixel_out_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (dithered_q.size() == 0)
            begin
                report("unexpected transaction", m_axis_tdata, 0);
            end
            else
            begin
                want = dithered_q.pop_front();
                if (m_axis_tdata[7:0] !== want.red)
                    report("out_red", m_axis_tdata[7:0], want.red);
                if (m_axis_tdata[15:8] !== want.green)
                    report("out_green", m_axis_tdata[15:8], want.green);
                if (m_axis_tdata[23:16] !== want.blue)
                    report("out_blue", m_axis_tdata[23:16], want.blue);
                if (m_axis_tdata[26:24] !== want.idx)
                    report("colour_index", m_axis_tdata[26:24], want.idx);
                if (m_axis_tdata[31:27] !== 5'd0)
                    report("zero fill", m_axis_tdata[31:27], 0);
                if (m_axis_tlast !== want.eoi)
                    report("end_of_image", m_axis_tlast, want.eoi);
            end
        end
    end

    dir_row_t dir_tab [30] = '{
        // after reset: one black entry, 1x1 image
        '{1'b0, ped_pkg::REG_PAIR0, 48'h0, 24'hFFFFFF, 1'b1, 24'h000000, 3'd0, 1'b1},
        '{1'b1, ped_pkg::REG_PAIR0, 48'hFFFFFF_000000, 24'h0, 1'b0, 24'h0, 3'd0, 1'b0},
        '{1'b1, ped_pkg::REG_COUNT, 48'd2, 24'h0, 1'b0, 24'h0, 3'd0, 1'b0},
        '{1'b1, ped_pkg::REG_WIDTH, 48'd2, 24'h0, 1'b0, 24'h0, 3'd0, 1'b0},
        '{1'b1, ped_pkg::REG_HEIGHT, 48'd2, 24'h0, 1'b0, 24'h0, 3'd0, 1'b0},
        '{1'b0, ped_pkg::REG_PAIR0, 48'h0, 24'h000000, 1'b1, 24'h000000, 3'd0, 1'b0},
        '{1'b0, ped_pkg::REG_PAIR0, 48'h0, 24'hFFFFFF, 1'b1, 24'hFFFFFF, 3'd1, 1'b0},
        '{1'b0, ped_pkg::REG_PAIR0, 48'h0, 24'h808080, 1'b0, 24'h0, 3'd0, 1'b0},
        '{1'b0, ped_pkg::REG_PAIR0, 48'h0, 24'h7F7F7F, 1'b0, 24'h0, 3'd0, 1'b0},
        '{1'b1, ped_pkg::REG_PAIR1, 48'h00FF00_FF0000, 24'h0, 1'b0, 24'h0, 3'd0, 1'b0},
        '{1'b1, ped_pkg::REG_PAIR2, 48'hFFFF00_0000FF, 24'h0, 1'b0, 24'h0, 3'd0, 1'b0},
        '{1'b1, ped_pkg::REG_PAIR3, 48'h123456_FEDCBA, 24'h0, 1'b0, 24'h0, 3'd0, 1'b0},
        // oversized count and width saturate, zero height acts as one
        '{1'b1, ped_pkg::REG_COUNT, 48'd15, 24'h0, 1'b0, 24'h0, 3'd0, 1'b0},
        '{1'b1, ped_pkg::REG_WIDTH, 48'd2047, 24'h0, 1'b0, 24'h0, 3'd0, 1'b0},
        '{1'b1, ped_pkg::REG_HEIGHT, 48'd0, 24'h0, 1'b0, 24'h0, 3'd0, 1'b0},
        '{1'b0, ped_pkg::REG_PAIR0, 48'h0, 24'h000000, 1'b0, 24'h0, 3'd0, 1'b0},
        '{1'b0, ped_pkg::REG_PAIR0, 48'h0, 24'hFFFFFF, 1'b0, 24'h0, 3'd0, 1'b0},
        '{1'b0, ped_pkg::REG_PAIR0, 48'h0, 24'hFF0000, 1'b0, 24'h0, 3'd0, 1'b0},
        '{1'b0, ped_pkg::REG_PAIR0, 48'h0, 24'h00FF00, 1'b0, 24'h0, 3'd0, 1'b0},
        '{1'b0, ped_pkg::REG_PAIR0, 48'h0, 24'h0000FF, 1'b0, 24'h0, 3'd0, 1'b0},
        '{1'b0, ped_pkg::REG_PAIR0, 48'h0, 24'h7FFF80, 1'b0, 24'h0, 3'd0, 1'b0},
        // zero count and width act as one; shrinking width mid-image ends the row
        '{1'b1, ped_pkg::REG_COUNT, 48'd0, 24'h0, 1'b0, 24'h0, 3'd0, 1'b0},
        '{1'b1, ped_pkg::REG_WIDTH, 48'd0, 24'h0, 1'b0, 24'h0, 3'd0, 1'b0},
        '{1'b1, ped_pkg::REG_HEIGHT, 48'd65535, 24'h0, 1'b0, 24'h0, 3'd0, 1'b0},
        '{1'b0, ped_pkg::REG_PAIR0, 48'h0, 24'hFFFFFF, 1'b0, 24'h0, 3'd0, 1'b0},
        '{1'b0, ped_pkg::REG_PAIR0, 48'h0, 24'h010203, 1'b0, 24'h0, 3'd0, 1'b0},
        '{1'b0, ped_pkg::REG_PAIR0, 48'h0, 24'h000000, 1'b0, 24'h0, 3'd0, 1'b0},
        '{1'b1, ped_pkg::REG_COUNT, 48'd8, 24'h0, 1'b0, 24'h0, 3'd0, 1'b0},
        '{1'b1, ped_pkg::REG_HEIGHT, 48'd1, 24'h0, 1'b0, 24'h0, 3'd0, 1'b0},
        '{1'b0, ped_pkg::REG_PAIR0, 48'h0, 24'h55AA33, 1'b0, 24'h0, 3'd0, 1'b0}
    };

    initial
    begin
        pixel_out_t want;
        bit         in_cfg;
        int         wv;
        int         hv;
        int         we;
        int         he;
        int         npix;
        for (int i = 0; i < 4; i++)
            pal_pair[i] = '0;
        pal_count = 4'd1;
        img_width = 11'd1;
        img_height = 16'd1;
        clear_diffusion();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        in_cfg = 1'b0;
        foreach (dir_tab[i])
        begin
            if (dir_tab[i].is_cfg)
            begin
                if (!in_cfg)
                    wait_idle();
                in_cfg = 1'b1;
                write_reg(dir_tab[i].reg_idx, dir_tab[i].reg_val);
            end
            else
            begin
                if (in_cfg)
                    cfg_we <= 1'b0;
                in_cfg = 1'b0;
                want.red = dir_tab[i].rgb[7:0];
                want.green = dir_tab[i].rgb[15:8];
                want.blue = dir_tab[i].rgb[23:16];
                want.idx = dir_tab[i].idx;
                want.eoi = dir_tab[i].eoi;
                send_pixel(dir_tab[i].pix, dir_tab[i].typed, want);
            end
        end

        while (sent < 1164)
        begin
            wait_idle();
            no_idle = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < 4; i++)
                write_reg(i[ped_pkg::CFG_IDX_W-1:0], rand_pair());
            write_reg(ped_pkg::REG_COUNT, 48'($urandom_range(0, 15)));
            case ($urandom_range(0, 9))
                0: wv = 0;
                1: wv = $urandom_range(1025, 2047);
                2: wv = 1024;
                default: wv = $urandom_range(1, 8);
            endcase
            case ($urandom_range(0, 7))
                0: hv = 0;
                1: hv = 65535;
                default: hv = $urandom_range(1, 4);
            endcase
            write_reg(ped_pkg::REG_WIDTH, 48'(wv));
            write_reg(ped_pkg::REG_HEIGHT, 48'(hv));
            cfg_we <= 1'b0;
            we = (wv == 0) ? 1 : ((wv > LINE_DEPTH) ? LINE_DEPTH : wv);
            he = (hv == 0) ? 1 : hv;
            // whole images where small, otherwise a partial one
            npix = (we * he <= 32) ? we * he * $urandom_range(1, 2) : $urandom_range(10, 60);
            for (int n = 0; n < npix; n++)
            begin
                want = '0;
                send_pixel({rand_chan(), rand_chan(), rand_chan()}, 1'b0, want);
            end
        end

        s_axis_tvalid <= 1'b0;
        while (dithered_q.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
